// File: rtl/quaternion_arith_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the quaternion arithmetic unit
// Clocked on clk and held off while rst is high.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_ARITH_UNIT_ASSERT_SVH
`define QUATERNION_ARITH_UNIT_ASSERT_SVH

// same-cycle implication
`define QAU_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define QAU_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/qau_pkg.sv
// ---------------------------------------------------------------------------
// qau_pkg
// Shared constants and codes of the quaternion arithmetic unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package qau_pkg;

  // default fixed-point format: Q16.16
  localparam int FRAC_BITS_DEF = 16;

  // root iterations (one result bit each) and divider quotient bits
  localparam int SQRT_STEPS = 32;
  localparam int DIV_QBITS  = 32;

  // operation codes
  typedef logic [2:0] op_code_t;
  localparam op_code_t OP_MUL   = 3'd0;
  localparam op_code_t OP_CONJ  = 3'd1;
  localparam op_code_t OP_NORM  = 3'd2;
  localparam op_code_t OP_NORMZ = 3'd3;
  localparam op_code_t OP_INV   = 3'd4;
  localparam op_code_t OP_IDENT = 3'd5;

  // result status
  typedef logic [1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_ZERO = 2'd1;
  localparam status_t ST_SAT  = 2'd2;

endpackage

// File: rtl/quaternion_arith_unit.sv
// ---------------------------------------------------------------------------
// quaternion_arith_unit: quaternion ALU in signed Qx.FRAC_BITS fixed point
// Throughput: one word per cycle while the skid word is free; the root
// pipeline and the divider in each lane are fully pipelined.
// Reset: synchronous rst empties the pipeline and the output stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quaternion_arith_unit_assert.svh"

module quaternion_arith_unit #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
  input  logic [255:0] s_axis_tdata,
  // operation
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // r_x, r_y, r_z, r_w, norm_out
  output logic [159:0] m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser
);

  localparam int DW     = 65 - FRAC_BITS;
  localparam int SQ_LAT = qau_pkg::SQRT_STEPS + 1;
  localparam int DV_LAT = qau_pkg::DIV_QBITS + 2;
  localparam int DLY_N  = SQ_LAT + DV_LAT;
  localparam int LAT    = DLY_N + 3;

  typedef struct packed {
    qau_pkg::op_code_t op;
    logic [3:0][31:0]  a;
    logic [DW-1:0]     m;
    logic              s_zero;
    logic [3:0][31:0]  pr;
    logic [3:0]        psat;
  } side_t;

  typedef struct packed {
    qau_pkg::status_t st;
    logic [159:0]     data;
  } res_t;

  logic              en;
  logic              acc;
  logic [LAT-1:0]    vld;
  logic [3:0][31:0]  a_in;
  logic [3:0][31:0]  b_in;

  qau_pkg::op_code_t op1, op2;
  logic [3:0][31:0]  a1, a2;
  logic [64:0]       s2;
  logic [64:0]       s_rnd;
  side_t             side_in;
  side_t             dly [0:DLY_N-1];

  logic [62:0]       sq   [0:3];
  logic [31:0]       prod [0:3];
  logic [3:0]        prod_sat;
  logic [31:0]       quo  [0:3];
  logic [3:0]        quo_sat;

  logic [32:0]       n_root;
  logic [32:0]       nd [0:DV_LAT-1];
  logic [DW-1:0]     den;
  logic              inv_neg;

  res_t              mrg_next, mrg;
  res_t              od, sd;
  logic              ov, sv;

  assign a_in = s_axis_tdata[127:0];
  assign b_in = s_axis_tdata[255:128];

  // the pipeline moves whenever the skid word is free
  assign en            = !sv;
  assign s_axis_tready = !sv;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // word valid flags along the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], acc};
    end
  end

  // operands alongside the lane front ends
  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= s_axis_tuser;
      a1  <= a_in;
      op2 <= op1;
      a2  <= a1;
      s2  <= 65'(sq[0]) + 65'(sq[1]) + 65'(sq[2]) + 65'(sq[3]);
    end
  end

  // component lanes
  qau_lane #(.FRAC_BITS(FRAC_BITS), .NEG(4'b0010)) u_lane_x (
    .clk (clk), .en (en),
    .u ({a_in[3], b_in[3], a_in[2], a_in[1]}),
    .v ({b_in[0], a_in[0], b_in[1], b_in[2]}),
    .sq_in (a_in[0]), .sq (sq[0]), .prod (prod[0]), .prod_sat (prod_sat[0]),
    .comp (dly[SQ_LAT-1].a[0]), .neg (inv_neg), .den (den),
    .quo (quo[0]), .quo_sat (quo_sat[0])
  );

  qau_lane #(.FRAC_BITS(FRAC_BITS), .NEG(4'b0010)) u_lane_y (
    .clk (clk), .en (en),
    .u ({a_in[3], b_in[3], a_in[0], a_in[2]}),
    .v ({b_in[1], a_in[1], b_in[2], b_in[0]}),
    .sq_in (a_in[1]), .sq (sq[1]), .prod (prod[1]), .prod_sat (prod_sat[1]),
    .comp (dly[SQ_LAT-1].a[1]), .neg (inv_neg), .den (den),
    .quo (quo[1]), .quo_sat (quo_sat[1])
  );

  qau_lane #(.FRAC_BITS(FRAC_BITS), .NEG(4'b0010)) u_lane_z (
    .clk (clk), .en (en),
    .u ({a_in[3], b_in[3], a_in[1], a_in[0]}),
    .v ({b_in[2], a_in[2], b_in[0], b_in[1]}),
    .sq_in (a_in[2]), .sq (sq[2]), .prod (prod[2]), .prod_sat (prod_sat[2]),
    .comp (dly[SQ_LAT-1].a[2]), .neg (inv_neg), .den (den),
    .quo (quo[2]), .quo_sat (quo_sat[2])
  );

  qau_lane #(.FRAC_BITS(FRAC_BITS), .NEG(4'b1110)) u_lane_w (
    .clk (clk), .en (en),
    .u ({a_in[2], a_in[1], a_in[0], a_in[3]}),
    .v ({b_in[2], b_in[1], b_in[0], b_in[3]}),
    .sq_in (a_in[3]), .sq (sq[3]), .prod (prod[3]), .prod_sat (prod_sat[3]),
    .comp (dly[SQ_LAT-1].a[3]), .neg (1'b0), .den (den),
    .quo (quo[3]), .quo_sat (quo_sat[3])
  );

  // shared root of the squared norm
  qau_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .s    (s2),
    .root (n_root)
  );

  // fixed-point squared norm and side data for the later stages
  always_comb begin
    s_rnd          = s2 + (65'(1) << (FRAC_BITS - 1));
    side_in.op     = op2;
    side_in.a      = a2;
    side_in.m      = s_rnd[64:FRAC_BITS];
    side_in.s_zero = (s2 == '0);
    side_in.pr     = {prod[3], prod[2], prod[1], prod[0]};
    side_in.psat   = prod_sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= side_in;
      for (int j = 1; j < DLY_N; j++) begin
        dly[j] <= dly[j-1];
      end
      nd[0] <= n_root;
      for (int j = 1; j < DV_LAT; j++) begin
        nd[j] <= nd[j-1];
      end
    end
  end

  // divisor: rounded norm for normalize, squared norm for inverse
  always_comb begin
    inv_neg = (dly[SQ_LAT-1].op == qau_pkg::OP_INV);
    den     = (dly[SQ_LAT-1].op == qau_pkg::OP_NORMZ) ? DW'(n_root) : dly[SQ_LAT-1].m;
  end

  // merge lane results by operation
  always_comb begin
    side_t              t;
    logic [31:0]        nsat;
    logic [3:0][31:0]   r;
    qau_pkg::status_t   st;
    t    = dly[DLY_N-1];
    nsat = nd[DV_LAT-1][32] ? 32'hFFFF_FFFF : nd[DV_LAT-1][31:0];
    r    = '0;
    st   = qau_pkg::ST_OK;
    case (t.op)
      qau_pkg::OP_MUL: begin
        r  = t.pr;
        st = (|t.psat) ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
      end
      qau_pkg::OP_CONJ: begin
        for (int i = 0; i < 3; i++) begin
          if (t.a[i] == 32'h8000_0000) begin
            r[i] = 32'h7FFF_FFFF;
            st   = qau_pkg::ST_SAT;
          end else begin
            r[i] = 32'd0 - t.a[i];
          end
        end
        r[3] = t.a[3];
      end
      qau_pkg::OP_NORM: begin
        st = nd[DV_LAT-1][32] ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
      end
      qau_pkg::OP_NORMZ: begin
        r  = {quo[3], quo[2], quo[1], quo[0]};
        st = (|quo_sat) ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
      end
      qau_pkg::OP_INV: begin
        if (t.s_zero) begin
          st = qau_pkg::ST_ZERO;
        end else begin
          r  = {quo[3], quo[2], quo[1], quo[0]};
          st = (|quo_sat) ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
        end
      end
      qau_pkg::OP_IDENT: begin
        r[3] = 32'(1) << FRAC_BITS;
      end
      default: begin
        r  = '0;
        st = qau_pkg::ST_OK;
      end
    endcase
    mrg_next.data = {nsat, r};
    mrg_next.st   = st;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mrg <= mrg_next;
    end
  end

  // output word and skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || m_axis_tready) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end else begin
        ov <= vld[LAT-1];
      end
    end else if (!sv && vld[LAT-1]) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || m_axis_tready) begin
      od <= sv ? sd : mrg;
    end else if (!sv) begin
      sd <= mrg;
    end
  end

  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = od.data;
  assign m_axis_tuser  = od.st;

  // checks
  `QAU_ASSERT_IMP(a_skid_has_out, sv, ov, "skid word held with output empty")
  `QAU_ASSERT_NXT(a_skid_hold, sv && !m_axis_tready, sv && $stable(sd), "skid word lost")
  `QAU_ASSERT_NXT(a_accept_enters, acc, vld[0], "accepted word not in pipeline")
  `QAU_ASSERT_IMP(a_zero_inv, m_axis_tvalid && m_axis_tuser == qau_pkg::ST_ZERO,
    m_axis_tdata[127:0] == '0, "zero-norm inverse with nonzero result")

endmodule

// File: rtl/qau_div.sv
// ---------------------------------------------------------------------------
// qau_div
// Pipelined restoring divider, one quotient bit per stage. Gives
// round(+-comp * 2^F / den) half away from zero, saturated to 32 bits signed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module qau_div #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [31:0]            comp,
  input  logic                   neg,
  input  logic [64-FRAC_BITS:0]  den,
  output logic [31:0]            quo,
  output logic                   quo_sat
);

  localparam int DW = 65 - FRAC_BITS;
  localparam int NW = (((32 + FRAC_BITS) > (DW - 1)) ? (32 + FRAC_BITS) : (DW - 1)) + 1;
  localparam int QB = qau_pkg::DIV_QBITS;
  localparam int CW = DW + QB;

  logic [31:0]    cmag;
  logic [NW-1:0]  num;
  logic           ovf_in;

  logic [CW-1:0]  rem  [0:QB];
  logic [DW-1:0]  dv   [0:QB];
  logic [QB-1:0]  q    [0:QB];
  logic           sgn  [0:QB];
  logic           zr   [0:QB];
  logic           ovf  [0:QB];

  // setup: magnitude, rounding offset and overflow test
  always_comb begin
    cmag   = comp[31] ? (~comp + 32'd1) : comp;
    num    = (NW'(cmag) << FRAC_BITS) + NW'(den >> 1);
    ovf_in = CW'(num) >= (CW'(den) << QB);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= CW'(num);
      dv[0]  <= den;
      q[0]   <= '0;
      sgn[0] <= comp[31] ^ neg;
      zr[0]  <= (comp == 32'd0);
      ovf[0] <= ovf_in;
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int B = QB - 1 - k;
    logic [CW-1:0] trial;
    logic          take;

    always_comb begin
      trial = CW'(dv[k]) << B;
      take  = rem[k] >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? (rem[k] - trial) : rem[k];
        q[k+1]    <= q[k] | (take ? (QB'(1) << B) : '0);
        dv[k+1]   <= dv[k];
        sgn[k+1]  <= sgn[k];
        zr[k+1]   <= zr[k];
        ovf[k+1]  <= ovf[k];
      end
    end
  end

  // sign and saturation
  always_ff @(posedge clk) begin
    if (en) begin
      if (zr[QB]) begin
        quo     <= '0;
        quo_sat <= 1'b0;
      end else if (ovf[QB]) begin
        quo     <= sgn[QB] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        quo_sat <= 1'b1;
      end else if (!sgn[QB]) begin
        quo     <= q[QB][31] ? 32'h7FFF_FFFF : q[QB];
        quo_sat <= q[QB][31];
      end else if (q[QB] > 32'h8000_0000) begin
        quo     <= 32'h8000_0000;
        quo_sat <= 1'b1;
      end else begin
        quo     <= 32'd0 - q[QB];
        quo_sat <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/qau_lane.sv
// ---------------------------------------------------------------------------
// qau_lane
// One component lane: four products and a rounded sum for the Hamilton
// product, the square of its own component, and the divider used by
// normalize and inverse.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module qau_lane #(
  parameter int         FRAC_BITS = qau_pkg::FRAC_BITS_DEF,
  parameter logic [3:0] NEG       = 4'b0000
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [3:0][31:0]      u,
  input  logic [3:0][31:0]      v,
  input  logic [31:0]           sq_in,
  output logic [62:0]           sq,
  output logic [31:0]           prod,
  output logic                  prod_sat,
  input  logic [31:0]           comp,
  input  logic                  neg,
  input  logic [64-FRAC_BITS:0] den,
  output logic [31:0]           quo,
  output logic                  quo_sat
);

  localparam int AW = 67;

  logic signed [63:0]   p [0:3];
  logic signed [63:0]   sq_full;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] rs;
  logic                 fits;

  // stage 1: products and square
  always_comb sq_full = $signed(sq_in) * $signed(sq_in);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        p[k] <= $signed(u[k]) * $signed(v[k]);
      end
      sq <= sq_full[62:0];
    end
  end

  // stage 2: signed sum, round half up, saturate
  always_comb begin
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      if (NEG[k]) begin
        acc = acc - AW'(p[k]);
      end else begin
        acc = acc + AW'(p[k]);
      end
    end
    rs   = (acc + (AW'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    fits = (rs[AW-1:31] == {(AW - 31){rs[31]}});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fits) begin
        prod <= rs[31:0];
      end else begin
        prod <= rs[AW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      prod_sat <= !fits;
    end
  end

  // divider for normalize and inverse
  qau_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .en      (en),
    .comp    (comp),
    .neg     (neg),
    .den     (den),
    .quo     (quo),
    .quo_sat (quo_sat)
  );

endmodule

// File: rtl/qau_sqrt.sv
// ---------------------------------------------------------------------------
// qau_sqrt
// Pipelined digit-by-digit square root of the 65-bit squared norm, one root
// bit per stage, rounded to nearest in a last stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module qau_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [64:0] s,
  output logic [32:0] root
);

  localparam int N = qau_pkg::SQRT_STEPS;

  logic [33:0] rem  [1:N];
  logic [31:0] rt   [1:N];
  logic [63:0] rad  [1:N];
  logic        hi   [1:N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [33:0] rem_p;
    logic [31:0] rt_p;
    logic [63:0] rad_p;
    logic        hi_p;
    logic [35:0] trial;
    logic [35:0] test;
    logic        take;

    if (k == 0) begin : g_first
      always_comb begin
        rem_p = '0;
        rt_p  = '0;
        rad_p = s[63:0];
        hi_p  = s[64];
      end
    end else begin : g_next
      always_comb begin
        rem_p = rem[k];
        rt_p  = rt[k];
        rad_p = rad[k];
        hi_p  = hi[k];
      end
    end

    always_comb begin
      trial = {rem_p, rad_p[63:62]};
      test  = {2'b00, rt_p, 2'b01};
      take  = trial >= test;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= take ? 34'(trial - test) : trial[33:0];
        rt[k+1]  <= {rt_p[30:0], take};
        rad[k+1] <= {rad_p[61:0], 2'b00};
        hi[k+1]  <= hi_p;
      end
    end
  end

  // round to nearest; a squared norm of 2^64 gives 2^32
  always_ff @(posedge clk) begin
    if (en) begin
      if (hi[N]) begin
        root <= 33'h1_0000_0000;
      end else begin
        root <= {1'b0, rt[N]} + 33'(rem[N] > {2'b00, rt[N]});
      end
    end
  end

endmodule

// File: tb/tb_quaternion_arith_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_quaternion_arith_unit
// Self-checking bench for the quaternion arithmetic unit. A queue of words
// (directed corner cases, then random quaternions over all operations) feeds
// a stream driver. A bit-exact fixed-point model predicts each result. A
// monitor compares the output words with the predictions in order. Both
// sides idle in random bursts.
// ---------------------------------------------------------------------------
module tb_quaternion_arith_unit;

  localparam int FB        = qau_pkg::FRAC_BITS_DEF;
  localparam int LATENCY   = 70;
  localparam int LIMIT     = 600000;
  localparam int N_RANDOM  = 2000;

  typedef struct packed {
    logic               hold;      // wait for all results before sending
    qau_pkg::op_code_t  op;
    logic [3:0][31:0]   a;         // x, y, z, w
    logic [3:0][31:0]   b;
  } quat_req_t;

  typedef struct packed {
    logic [3:0][31:0]   r;
    logic [31:0]        nrm;
    qau_pkg::status_t   st;
  } quat_res_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  quat_req_t pending_q[$];
  quat_res_t expected_q[$];
  quat_req_t cur_req;
  int        errors = 0;
  int        cycles = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        op_seen[8];
  int        src_idle = 0;
  int        snk_idle = 0;
  bit        tail = 1'b0;   // no idling near the end

  quaternion_arith_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---- fixed-point model ----
  function automatic logic [31:0] clamp32(logic signed [67:0] v,
                                          ref qau_pkg::status_t st);
    if (v > 68'sd2147483647) begin
      st = qau_pkg::ST_SAT;
      return 32'h7FFF_FFFF;
    end
    if (v < -68'sd2147483648) begin
      st = qau_pkg::ST_SAT;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, bt, n;
    n = v; r = '0; bt = 64'h4000_0000_0000_0000;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n = n - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // divide rounding half away from zero
  function automatic logic signed [67:0] div_away(logic signed [67:0] num, logic [67:0] den);
    logic [67:0] mag, q;
    mag = num < 0 ? 68'(-num) : 68'(num);
    q = (mag + den / 2) / den;
    return num < 0 ? -$signed(q) : $signed(q);
  endfunction

  // sum of four products, rounded half up to the fixed-point grid
  function automatic logic signed [67:0] dot4(longint p0, longint p1, longint p2, longint p3);
    logic signed [67:0] acc;
    acc = p0;
    acc = acc + p1 + p2 + p3;
    return (acc + (68'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  function automatic quat_res_t predict_quat(quat_req_t q);
    quat_res_t res;
    longint a[4], b[4];
    logic signed [67:0] v[4];
    logic [67:0] s, n, m;
    qau_pkg::status_t st, nst;
    st = qau_pkg::ST_OK; nst = qau_pkg::ST_OK;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'($signed(q.a[i]));
      b[i] = longint'($signed(q.b[i]));
      v[i] = '0;
    end
    s = '0;
    for (int i = 0; i < 4; i++) s = s + 68'(a[i] * a[i]);
    if (s[67:64] != 0) begin
      n = 68'd1 << 32;
    end else begin
      n = int_sqrt(s[63:0]);
      if (s - n * n > n) n = n + 1;
    end
    res.nrm = n[31:0];
    if (n > 68'hFFFF_FFFF) begin
      res.nrm = 32'hFFFF_FFFF;
      nst = qau_pkg::ST_SAT;
    end
    case (q.op)
      qau_pkg::OP_MUL: begin
        v[0] = dot4(a[1] * b[2], -(a[2] * b[1]), b[3] * a[0], a[3] * b[0]);
        v[1] = dot4(a[2] * b[0], -(a[0] * b[2]), b[3] * a[1], a[3] * b[1]);
        v[2] = dot4(a[0] * b[1], -(a[1] * b[0]), b[3] * a[2], a[3] * b[2]);
        v[3] = dot4(a[3] * b[3], -(a[0] * b[0]), -(a[1] * b[1]), -(a[2] * b[2]));
      end
      qau_pkg::OP_CONJ: begin
        for (int i = 0; i < 3; i++) v[i] = -a[i];
        v[3] = a[3];
      end
      qau_pkg::OP_NORM: st = nst;
      qau_pkg::OP_NORMZ: begin
        for (int i = 0; i < 4; i++)
          if (a[i] != 0) v[i] = div_away(68'(a[i]) <<< FB, n);
      end
      qau_pkg::OP_INV: begin
        if (s == 0) begin
          st = qau_pkg::ST_ZERO;
        end else begin
          m = (s + (68'd1 << (FB - 1))) >> FB;
          for (int i = 0; i < 4; i++) begin
            logic signed [67:0] c;
            c = (i == 3) ? 68'(a[i]) : -68'(a[i]);
            if (c == 0) v[i] = '0;
            else if (m == 0) v[i] = c < 0 ? -(68'sd1 <<< 40) : (68'sd1 <<< 40);
            else v[i] = div_away(c <<< FB, m);
          end
        end
      end
      qau_pkg::OP_IDENT: v[3] = 68'sd1 <<< FB;
      default: ;
    endcase
    for (int i = 0; i < 4; i++) res.r[i] = clamp32(v[i], st);
    res.st = st;
    return res;
  endfunction

  // ---- source side ----
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(predict_quat(cur_req));
        op_seen[cur_req.op]++;
        n_sent++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the word
      end else if (src_idle > 0) begin
        src_idle--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() == 0 ||
                   (pending_q[0].hold && (expected_q.size() != 0 ||
                                          (s_axis_tvalid && s_axis_tready)))) begin
        s_axis_tvalid <= 1'b0;
      end else if (!tail && $urandom_range(0, 15) == 0) begin
        src_idle = $urandom_range(0, 12);
        s_axis_tvalid <= 1'b0;
      end else begin
        cur_req = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cur_req.b, cur_req.a};
        s_axis_tuser  <= cur_req.op;
      end
    end
  end

  // ---- sink side: check and stall ----
  always @(posedge clk) begin
    quat_res_t got, exp_res;
    cycles++;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.r   = m_axis_tdata[127:0];
        got.nrm = m_axis_tdata[159:128];
        got.st  = m_axis_tuser;
        if (expected_q.size() == 0) begin
          $error("result word with no expectation waiting");
          errors++;
        end else begin
          exp_res = expected_q.pop_front();
          n_checked++;
          for (int i = 0; i < 4; i++)
            if (got.r[i] !== exp_res.r[i]) begin
              $error("r_%s: expected %h, got %h", i == 0 ? "x" : i == 1 ? "y" :
                     i == 2 ? "z" : "w", exp_res.r[i], got.r[i]);
              errors++;
            end
          if (got.nrm !== exp_res.nrm) begin
            $error("norm_out: expected %h, got %h", exp_res.nrm, got.nrm);
            errors++;
          end
          if (got.st !== exp_res.st) begin
            $error("status: expected %0d, got %0d", exp_res.st, got.st);
            errors++;
          end
        end
      end
      if (snk_idle > 0) begin
        snk_idle--;
        m_axis_tready <= 1'b0;
      end else if (!tail && $urandom_range(0, 15) == 0) begin
        snk_idle = $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---- stimulus ----
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3, 4, 5: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
      6: return 32'($signed($urandom_range(0, 255)) - 128);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(qau_pkg::op_code_t op, logic [3:0][31:0] a,
                         logic [3:0][31:0] b, bit hold);
    quat_req_t q;
    q.hold = hold; q.op = op; q.a = a; q.b = b;
    pending_q.push_back(q);
  endtask

  initial begin
    logic [3:0][31:0] mx, mn, zr, one, tiny, mix;
    quat_req_t q;
    mx = {4{32'h7FFF_FFFF}};
    mn = {4{32'h8000_0000}};
    zr = '0;
    one = {32'h0001_0000, 96'd0};
    tiny = {96'd0, 32'h0000_0001};
    mix = {32'h0001_8000, 32'hFFFF_0000, 32'h0000_4000, 32'h8000_0000};

    // directed corners
    add_req(qau_pkg::OP_MUL, mx, mx, 0);
    add_req(qau_pkg::OP_MUL, mn, mn, 0);
    add_req(qau_pkg::OP_MUL, mx, mn, 0);
    add_req(qau_pkg::OP_MUL, one, mix, 0);
    add_req(qau_pkg::OP_MUL, mix, mix, 0);
    add_req(qau_pkg::OP_CONJ, mn, zr, 0);
    add_req(qau_pkg::OP_CONJ, mix, mx, 0);
    add_req(qau_pkg::OP_NORM, mn, zr, 0);
    add_req(qau_pkg::OP_NORM, mx, zr, 0);
    add_req(qau_pkg::OP_NORM, zr, zr, 0);
    add_req(qau_pkg::OP_NORM, {32'hFFFF_FFFF, 96'd0}, zr, 0);
    add_req(qau_pkg::OP_NORMZ, zr, zr, 0);
    add_req(qau_pkg::OP_NORMZ, mix, zr, 0);
    add_req(qau_pkg::OP_NORMZ, mn, zr, 0);
    add_req(qau_pkg::OP_NORMZ, tiny, zr, 0);
    add_req(qau_pkg::OP_INV, zr, zr, 0);
    add_req(qau_pkg::OP_INV, tiny, zr, 0);
    add_req(qau_pkg::OP_INV, {32'h0000_0001, 32'hFFFF_FFFF, 64'd0}, zr, 0);
    add_req(qau_pkg::OP_INV, one, zr, 0);
    add_req(qau_pkg::OP_INV, mix, zr, 0);
    add_req(qau_pkg::OP_INV, mn, zr, 0);
    add_req(qau_pkg::OP_IDENT, mx, mn, 0);
    add_req(qau_pkg::op_code_t'(6), mix, mx, 0);
    add_req(qau_pkg::op_code_t'(7), mn, mx, 0);

    // random mix; now and then drain the pipeline before sending
    for (int k = 0; k < N_RANDOM; k++) begin
      q.hold = (k % 500 == 250);
      q.op = ($urandom_range(0, 19) == 0) ? qau_pkg::op_code_t'($urandom_range(6, 7))
                                           : qau_pkg::op_code_t'($urandom_range(0, 5));
      for (int i = 0; i < 4; i++) begin
        q.a[i] = rand_comp();
        q.b[i] = rand_comp();
      end
      // small quaternions exercise the tiny-inverse path
      if ($urandom_range(0, 19) == 0)
        for (int i = 0; i < 4; i++) q.a[i] = 32'($signed($urandom_range(0, 400)) - 200);
      pending_q.push_back(q);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() >= 200) @(posedge clk);
    tail = 1'b1;
    while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 30) @(posedge clk);

    $display("Sent %0d words, checked %0d results", n_sent, n_checked);
    $display("ops 0-7 seen: %0d %0d %0d %0d %0d %0d %0d %0d",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3],
             op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/qau_pkg.sv
rtl/qau_div.sv
rtl/qau_lane.sv
rtl/qau_sqrt.sv
rtl/quaternion_arith_unit.sv
tb/tb_quaternion_arith_unit.sv
